// ===== rtl/qcpf_pkg.sv =====
`default_nettype none

package qcpf_pkg;

   // field widths
   localparam int CNT_W  = 10;
   localparam int PRES_W = 12;

   // config port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_VALIDATION_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STEP          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIFT_LIMIT       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSISTENCE       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIKE_LIMIT       = 3'd4;

   // stream packing
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 3;

   // configuration register set
   typedef struct packed {
      logic                 validation_enable;
      logic [CNT_W-1:0]     max_step;
      logic [CNT_W-1:0]     drift_limit;
      logic [7:0]           persistence;
      logic [10:0]          spike_limit;
   } qcpf_cfg_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic mult;
      logic cmp;
      logic div_step;
      logic div_take;
      logic push;
      logic pres;
      logic emit;
   } qcpf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic val_en;
      logic hist_nonempty;
      logic fallback_now;
      logic div_busy;
   } qcpf_sts_type;

endpackage

`default_nettype wire

// ===== rtl/qcpf_ctrl.sv =====
`default_nettype none

module qcpf_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   input  qcpf_pkg::qcpf_sts_type sts,
   output qcpf_pkg::qcpf_cmd_type cmd
);
   import qcpf_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_STEP = 3'd1;
   localparam logic [2:0] ST_MULT = 3'd2;
   localparam logic [2:0] ST_CMP  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_PUSH = 3'd5;
   localparam logic [2:0] ST_PRES = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign out_free   = !valid_ff || rsp_tready;

   // sequencing
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (!sts.val_en)
               state_in = ST_PRES;
            else if (sts.hist_nonempty)
               state_in = ST_MULT;
            else
               state_in = ST_PUSH;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = sts.fallback_now ? ST_DIV : ST_PUSH;
         end
         ST_DIV: begin
            if (sts.div_busy) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.div_take = 1'b1;
               state_in     = ST_PUSH;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = ST_PRES;
         end
         ST_PRES: begin
            cmd.pres = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output valid
   always_comb begin
      valid_in = valid_ff;
      if (cmd.emit)
         valid_in = 1'b1;
      else if (rsp_tready)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/qcpf_datapath.sv =====
`default_nettype none

module qcpf_datapath #(
   parameter int HISTORY_DEPTH = 10
) (
   input  wire                                clock,
   input  wire                                reset,
   input  qcpf_pkg::qcpf_cfg_type             cfg,
   input  qcpf_pkg::qcpf_cmd_type             cmd,
   output qcpf_pkg::qcpf_sts_type             sts,
   input  wire [qcpf_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic [qcpf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [qcpf_pkg::RSP_USER_W-1:0]    rsp_tuser
);
   import qcpf_pkg::*;

   localparam int FW  = $clog2(HISTORY_DEPTH + 1);
   localparam int SW  = CNT_W + FW;
   localparam int AW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int DCW = $clog2(SW + 1);

   // request fields
   logic [CNT_W-1:0] raw_ff, arr_ff, lev_ff;

   // per-item working registers
   logic [CNT_W-1:0]  acc_ff;
   logic              rej_ff, fallback_ff;
   logic [SW-1:0]     scaled_ff, lim_ff;
   logic [CNT_W-1:0]  oldest_ff;
   logic [PRES_W-1:0] pres_ff;

   // persistent state
   logic [CNT_W-1:0]  last_ff;
   logic [FW-1:0]     fill_ff;
   logic [AW-1:0]     head_ff;
   logic [SW-1:0]     total_ff;
   logic [7:0]        run_ff, run_in;
   logic [PRES_W-1:0] prev_ff;

   // divider
   logic [SW-1:0]     quo_ff;
   logic [FW-1:0]     rem_ff;
   logic [DCW-1:0]    dcnt_ff;

   // history ring
   logic [CNT_W-1:0]  ring [HISTORY_DEPTH];

   // output register
   logic [CNT_W-1:0]  out_acc_ff;
   logic [PRES_W-1:0] out_pres_ff;
   logic              out_rej_ff, out_fb_ff, out_spike_ff;

   // step check
   logic [CNT_W-1:0] step_diff;
   assign step_diff = (raw_ff >= last_ff) ? raw_ff - last_ff : last_ff - raw_ff;

   // drift check
   logic [SW-1:0] dev;
   logic          drift;
   assign dev   = (scaled_ff >= total_ff) ? scaled_ff - total_ff : total_ff - scaled_ff;
   assign drift = dev > lim_ff;

   always_comb begin
      run_in = '0;
      if (drift)
         run_in = (run_ff == 8'hFF) ? run_ff : run_ff + 8'd1;
   end

   // one restoring divide step
   logic [FW:0]   rem_sh;
   logic          rem_ge;
   logic [FW:0]   rem_sub;
   assign rem_sh  = {rem_ff, quo_ff[SW-1]};
   assign rem_ge  = rem_sh >= {1'b0, fill_ff};
   assign rem_sub = rem_sh - {1'b0, fill_ff};

   // pressure and spike
   logic [PRES_W-1:0] pres_in;
   logic [PRES_W:0]   dp;
   logic              spike;
   assign pres_in = PRES_W'(acc_ff) + PRES_W'(arr_ff) - PRES_W'(lev_ff);
   assign dp      = {pres_ff[PRES_W-1], pres_ff} - {prev_ff[PRES_W-1], prev_ff};
   assign spike   = $signed(dp) > $signed({2'b00, cfg.spike_limit});

   // history update
   logic [SW-1:0] total_in;
   logic          full;
   assign full     = (fill_ff == FW'(HISTORY_DEPTH));
   assign total_in = total_ff + SW'(acc_ff) - (full ? SW'(oldest_ff) : '0);

   assign sts.val_en        = cfg.validation_enable;
   assign sts.hist_nonempty = (fill_ff != '0);
   assign sts.fallback_now  = drift && (run_in >= cfg.persistence);
   assign sts.div_busy      = (dcnt_ff != '0);

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_ff <= req_tdata[CNT_W-1:0];
         arr_ff <= req_tdata[2*CNT_W-1:CNT_W];
         lev_ff <= req_tdata[3*CNT_W-1:2*CNT_W];
      end
      if (cmd.step) begin
         fallback_ff <= 1'b0;
         oldest_ff   <= ring[head_ff];
         if (!cfg.validation_enable || step_diff <= cfg.max_step) begin
            acc_ff <= raw_ff;
            rej_ff <= 1'b0;
         end else begin
            acc_ff <= last_ff;
            rej_ff <= 1'b1;
         end
      end
      if (cmd.mult) begin
         scaled_ff <= SW'(acc_ff) * SW'(fill_ff);
         lim_ff    <= SW'(cfg.drift_limit) * SW'(fill_ff);
      end
      if (cmd.cmp) begin
         fallback_ff <= sts.fallback_now;
         quo_ff      <= total_ff;
         rem_ff      <= '0;
      end
      if (cmd.div_step) begin
         quo_ff <= {quo_ff[SW-2:0], rem_ge};
         rem_ff <= rem_ge ? rem_sub[FW-1:0] : rem_sh[FW-1:0];
      end
      if (cmd.div_take)
         acc_ff <= quo_ff[CNT_W-1:0];
      if (cmd.push)
         ring[head_ff] <= acc_ff;
      if (cmd.pres)
         pres_ff <= pres_in;
      if (cmd.emit) begin
         out_acc_ff   <= acc_ff;
         out_pres_ff  <= pres_ff;
         out_rej_ff   <= rej_ff;
         out_fb_ff    <= fallback_ff;
         out_spike_ff <= spike;
      end
   end

   // persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         fill_ff  <= '0;
         head_ff  <= '0;
         total_ff <= '0;
         run_ff   <= '0;
         prev_ff  <= '0;
         dcnt_ff  <= '0;
      end else begin
         if (cmd.step && (!cfg.validation_enable || step_diff <= cfg.max_step))
            last_ff <= raw_ff;
         if (cmd.cmp) begin
            run_ff  <= run_in;
            dcnt_ff <= DCW'(SW);
         end
         if (cmd.div_step)
            dcnt_ff <= dcnt_ff - DCW'(1);
         if (cmd.push) begin
            total_ff <= total_in;
            if (!full)
               fill_ff <= fill_ff + FW'(1);
            head_ff <= (head_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : head_ff + AW'(1);
         end
         if (cmd.emit)
            prev_ff <= pres_ff;
      end
   end

   assign rsp_tdata = {{(RSP_DATA_W - CNT_W - PRES_W){1'b0}}, out_pres_ff, out_acc_ff};
   assign rsp_tuser = {out_spike_ff, out_fb_ff, out_rej_ff};

`ifndef NO_ASSERTIONS
   // fill count never passes the ring depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(HISTORY_DEPTH))
      else $error("history fill beyond depth");

   // head stays inside the ring
   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= AW'(HISTORY_DEPTH - 1))
      else $error("history head out of range");

   // until the ring is full the head follows the fill count
   a_head_tracks: assert property (@(posedge clock) disable iff (reset)
      !full |-> (FW'(head_ff) == fill_ff))
      else $error("history head and fill disagree");

   // running total is bounded by the entries it holds
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= SW'(fill_ff) * SW'(1023))
      else $error("history total too large");
`endif

endmodule

`default_nettype wire

// ===== rtl/queue_count_plausibility_filter.sv =====
// A request is loaded and step-checked; with validation off it goes straight to the
// pressure stage, with an empty history to the ring push, with the drift check through
// multiply and compare, and on a mean fallback through the bit-serial divider as well.
// The controller handles one item at a time and accepts a new request only after the
// last result is emitted, and a result waits in the output register. Synchronous
// active-high reset clears history, counters and restores configuration defaults.
`default_nettype none

module queue_count_plausibility_filter #(
   parameter int HISTORY_DEPTH = 10
) (
   input  wire                                clock,
   input  wire                                reset,
   // request stream
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // [9:0] raw_count, [19:10] arriving, [29:20] leaving, [31:30] zero
   input  wire [qcpf_pkg::REQ_DATA_W-1:0]     req_tdata,
   // result stream
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // [9:0] accepted_count, [21:10] pressure_value, [23:22] zero
   output logic [qcpf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] step_rejected, [1] drift_fallback, [2] spike_seen
   output logic [qcpf_pkg::RSP_USER_W-1:0]    rsp_tuser,
   // configuration writes
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire [qcpf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [qcpf_pkg::CSR_DATA_W-1:0]     csr_data
);
   import qcpf_pkg::*;

   qcpf_cfg_type cfg_ff;
   qcpf_cmd_type cmd;
   qcpf_sts_type sts;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.validation_enable <= 1'b1;
         cfg_ff.max_step          <= 10'd10;
         cfg_ff.drift_limit       <= 10'd5;
         cfg_ff.persistence       <= 8'd3;
         cfg_ff.spike_limit       <= 11'd5;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_VALIDATION_ENABLE: cfg_ff.validation_enable <= csr_data[0];
            CSR_MAX_STEP:          cfg_ff.max_step          <= csr_data[CNT_W-1:0];
            CSR_DRIFT_LIMIT:       cfg_ff.drift_limit       <= csr_data[CNT_W-1:0];
            CSR_PERSISTENCE:       cfg_ff.persistence       <= csr_data[7:0];
            CSR_SPIKE_LIMIT:       cfg_ff.spike_limit       <= csr_data;
            default: ;
         endcase
      end
   end

   qcpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   qcpf_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== test/qcpf_result_check.sv =====
`timescale 1ns / 1ps

// Watches the request, result and csr channels, tracks the filter state and
// compares every result against the predicted one.
module qcpf_result_check #(
   parameter int HIST_DEPTH = 10
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   input  wire                              req_tready,
   input  wire [qcpf_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire                              rsp_tvalid,
   input  wire                              rsp_tready,
   input  wire [qcpf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire [qcpf_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input  wire                              csr_valid,
   input  wire                              csr_ready,
   input  wire [qcpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [qcpf_pkg::CSR_DATA_W-1:0]   csr_data,
   output int                               fail_count,
   output int                               pending_count
);
   import qcpf_pkg::*;

   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic [PRES_W-1:0] pressure;
      logic              rejected;
      logic              fallback;
      logic              spike;
   } tick_result_type;

   // shadow configuration and filter state
   qcpf_cfg_type cfg;
   int           held_count;
   int           hist_mem [HIST_DEPTH];
   int           hist_cnt;
   int           hist_wr;
   int           hist_sum;
   int           drift_ticks;
   int           prior_pressure;

   tick_result_type expected_ticks [$];
   int              err_total = 0;

   // one measurement tick through step check, drift check and pressure
   function automatic tick_result_type filter_tick(input int raw, input int arr,
                                                   input int lev);
      tick_result_type r;
      int acc, gap, scaled, dev, pres;
      r   = '0;
      acc = raw;
      if (!cfg.validation_enable) begin
         held_count = raw;
      end else begin
         gap = (raw >= held_count) ? raw - held_count : held_count - raw;
         if (gap <= int'(cfg.max_step)) begin
            held_count = raw;
         end else begin
            acc        = held_count;
            r.rejected = 1'b1;
         end
         // no drift test until the history has an entry
         if (hist_cnt > 0) begin
            scaled = acc * hist_cnt;
            dev    = (scaled >= hist_sum) ? scaled - hist_sum : hist_sum - scaled;
            if (dev > int'(cfg.drift_limit) * hist_cnt) begin
               if (drift_ticks < 255) drift_ticks++;
               if (drift_ticks >= int'(cfg.persistence)) begin
                  acc        = hist_sum / hist_cnt;
                  r.fallback = 1'b1;
               end
            end else begin
               drift_ticks = 0;
            end
         end
         // output value enters the ring, oldest one drops out when full
         if (hist_cnt < HIST_DEPTH) hist_cnt++;
         else hist_sum -= hist_mem[hist_wr];
         hist_mem[hist_wr] = acc;
         hist_sum += acc;
         hist_wr = (hist_wr + 1) % HIST_DEPTH;
      end
      pres           = acc + arr - lev;
      r.spike        = ((pres - prior_pressure) > int'(cfg.spike_limit));
      prior_pressure = pres;
      r.count        = acc[CNT_W-1:0];
      r.pressure     = pres[PRES_W-1:0];
      return r;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         err_total++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      tick_result_type want, got;
      if (reset) begin
         cfg.validation_enable = 1'b1;
         cfg.max_step          = 10;
         cfg.drift_limit       = 5;
         cfg.persistence       = 3;
         cfg.spike_limit       = 5;
         held_count     = 0;
         hist_cnt       = 0;
         hist_wr        = 0;
         hist_sum       = 0;
         drift_ticks    = 0;
         prior_pressure = 0;
         expected_ticks.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VALIDATION_ENABLE: cfg.validation_enable = csr_data[0];
               CSR_MAX_STEP:          cfg.max_step          = csr_data[CNT_W-1:0];
               CSR_DRIFT_LIMIT:       cfg.drift_limit       = csr_data[CNT_W-1:0];
               CSR_PERSISTENCE:       cfg.persistence       = csr_data[7:0];
               CSR_SPIKE_LIMIT:       cfg.spike_limit       = csr_data[10:0];
               default: ;
            endcase
         end
         // result side first: a request accepted now cannot answer at once
         if (rsp_tvalid && rsp_tready) begin
            got.count    = rsp_tdata[9:0];
            got.pressure = rsp_tdata[21:10];
            got.rejected = rsp_tuser[0];
            got.fallback = rsp_tuser[1];
            got.spike    = rsp_tuser[2];
            if (expected_ticks.size() == 0) begin
               err_total++;
               $display("%0t: unexpected result, expected none, got count %0d pressure %0d",
                        $time, got.count, $signed(got.pressure));
            end else begin
               want = expected_ticks[0];
               expected_ticks.delete(0);
               check_field("accepted_count", int'(want.count), int'(got.count));
               check_field("pressure_value", int'($signed(want.pressure)),
                           int'($signed(got.pressure)));
               check_field("step_rejected", int'(want.rejected), int'(got.rejected));
               check_field("drift_fallback", int'(want.fallback), int'(got.fallback));
               check_field("spike_seen", int'(want.spike), int'(got.spike));
            end
         end
         if (req_tvalid && req_tready)
            expected_ticks.insert(expected_ticks.size(),
                                  filter_tick(int'(req_tdata[9:0]), int'(req_tdata[19:10]),
                                              int'(req_tdata[29:20])));
      end
      fail_count    <= err_total;
      pending_count <= expected_ticks.size();
   end

endmodule

// ===== test/tb_queue_count_plausibility_filter.sv =====
`timescale 1ns / 1ps

module tb_queue_count_plausibility_filter;
   import qcpf_pkg::*;

   localparam int HIST_DEPTH    = 10;
   localparam int HOLD_CYCLES   = 400;
   localparam int IDLE_LIMIT    = 5000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 105;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [RSP_USER_W-1:0]   rsp_tuser;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   int   fail_count;
   int   pending_count;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic hold_arm  = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   int   quiet_cycles  = 0;
   int   items_sent    = 0;
   int   csr_writes    = 0;
   int   settings_used = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   queue_count_plausibility_filter #(.HISTORY_DEPTH(HIST_DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   qcpf_result_check #(.HIST_DEPTH(HIST_DEPTH)) result_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // result receiver: long hold when armed, otherwise random stalls
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_arm != hold_seen) begin
         hold_seen  <= hold_arm;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one request; valid stays up unless the sender idles afterwards
   task automatic send_item(input logic [9:0] raw, input logic [9:0] arr,
                            input logic [9:0] lev);
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, lev, arr, raw};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // stop sending and wait for every outstanding result
   task automatic quiesce();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // write all five registers back to back
   task automatic apply_settings(input int en, input int step, input int drift,
                                 input int persist, input int spike);
      logic [CSR_IDX_W-1:0]  idxs [5];
      logic [CSR_DATA_W-1:0] vals [5];
      idxs = '{CSR_VALIDATION_ENABLE, CSR_MAX_STEP, CSR_DRIFT_LIMIT, CSR_PERSISTENCE,
               CSR_SPIKE_LIMIT};
      vals[0] = CSR_DATA_W'(en);
      vals[1] = CSR_DATA_W'(step);
      vals[2] = CSR_DATA_W'(drift);
      vals[3] = CSR_DATA_W'(persist);
      vals[4] = CSR_DATA_W'(spike);
      csr_valid <= 1'b1;
      for (int i = 0; i < 5; i++) begin
         csr_index <= idxs[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         csr_writes++;
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // arrival / departure counts: mostly small, sometimes full range or extreme
   function automatic int pick_flow();
      case ($urandom_range(3))
         0, 1:    return $urandom_range(0, 15);
         2:       return $urandom_range(0, 1023);
         default: return ($urandom_range(1) != 0) ? 1023 : 0;
      endcase
   endfunction

   initial begin : stimulus
      int cur, ramp_dir, wob, sel;
      int en, step, drift, persist, spike;
      cur      = 0;
      ramp_dir = 1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: empty history, spike, rejected step, ramp into fallback
      send_item(0, 0, 0);
      send_item(5, 1023, 0);
      send_item(1023, 0, 1023);
      send_item(10, 0, 0);
      send_item(15, 3, 2);
      send_item(25, 0, 0);
      send_item(35, 0, 0);
      send_item(45, 0, 0);
      send_item(55, 7, 0);
      send_item(55, 0, 0);

      // validation off: raw passes, pressure extremes, history left alone
      quiesce();
      apply_settings(0, 10, 5, 3, 5);
      send_item(1023, 1023, 0);
      send_item(0, 0, 1023);
      send_item(700, 5, 5);

      // back on: far from the old history mean, drift builds up
      quiesce();
      apply_settings(1, 10, 5, 3, 5);
      send_item(705, 0, 0);
      send_item(706, 0, 0);
      send_item(707, 0, 0);
      send_item(708, 0, 0);

      // persistence zero falls back on the first drift tick
      quiesce();
      apply_settings(1, 1023, 0, 0, 0);
      send_item(300, 0, 0);
      send_item(0, 0, 0);
      send_item(1023, 1023, 1023);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin en = 1; step = 10;   drift = 5;    persist = 3;   spike = 5;    end
            1: begin en = 1; step = 1023; drift = 0;    persist = 1;   spike = 0;    end
            2: begin en = 1; step = 0;    drift = 1023; persist = 255; spike = 2047; end
            3: begin en = 0; step = 500;  drift = 20;   persist = 2;   spike = 100;  end
            4: begin en = 1; step = 50;   drift = 10;   persist = 0;   spike = 30;   end
            default: begin
               en      = ($urandom_range(3) != 0);
               step    = $urandom_range(0, 40);
               drift   = $urandom_range(0, 30);
               persist = $urandom_range(1, 8);
               spike   = $urandom_range(0, 2047);
            end
         endcase
         quiesce();
         apply_settings(en, step, drift, persist, spike);
         case (p % 4)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 48; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 48; end
            default: begin send_idle_pct = 9;  rsp_stall_pct = 9;  end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver hold while requests keep coming
            if (p == 2 && n == PHASE_ITEMS / 2) hold_arm <= ~hold_arm;
            sel = $urandom_range(99);
            if (sel < 55) begin
               wob = $urandom_range(0, 12);
               cur = cur + $urandom_range(0, 2 * wob) - wob;
            end else if (sel < 80) begin
               cur = cur + ramp_dir * $urandom_range(6, 30);
               if ($urandom_range(9) == 0) ramp_dir = -ramp_dir;
            end else if (sel < 95) begin
               cur = $urandom_range(0, 1023);
            end else begin
               cur = ($urandom_range(1) != 0) ? 1023 : 0;
            end
            if (cur < 0) cur = 0;
            if (cur > 1023) cur = 1023;
            send_item(10'(cur), 10'(pick_flow()), 10'(pick_flow()));
         end
      end

      quiesce();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Ran %0d requests through %0d register settings (%0d csr writes),",
               items_sent, settings_used, csr_writes);
      $display("with sender gaps, receiver stalls and one long receiver hold.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
